FILE: rtl/circle_box_collision_resolve_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circle/box collision block
// Each check takes a label, clock, active-low reset, condition, consequence
// and message. Defining NO_ASSERTIONS drops all of them.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_BOX_COLLISION_RESOLVE_TOP_ASSERT_SVH
`define CIRCLE_BOX_COLLISION_RESOLVE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequence holds in the same cycle as the condition
`define CBCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the condition
`define CBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CBCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/cbcr_pkg.sv
// ----------------------------------------------------------------------------
// cbcr_pkg
// Shared widths, constants and types of the circle/box collision block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbcr_pkg;

    localparam int CBCR_POS_W   = 24;  // signed positions
    localparam int CBCR_LEN_W   = 20;  // unsigned radius and box sizes
    localparam int CBCR_FRAC_BITS = 8;

    // square root unit: 42-bit radicand, 21-bit root
    localparam int CBCR_SQ_IN_W   = 42;
    localparam int CBCR_ROOT_W    = 21;
    localparam int CBCR_SQ_REM_W  = 23;

    // divider: 42-bit dividend, 21-bit divisor and quotient
    localparam int CBCR_DIV_NUM_W = 42;

    // distance used when the centre sits on the box: 0.01 in fixed point, at least 1
    localparam int CBCR_DIST_RAW  = ((1 << CBCR_FRAC_BITS) + 50) / 100;
    localparam int CBCR_DIST_INT  = (CBCR_DIST_RAW < 1) ? 1 : CBCR_DIST_RAW;
    localparam logic [CBCR_ROOT_W-1:0] CBCR_DIST_ZERO = CBCR_ROOT_W'(CBCR_DIST_INT);

    typedef struct packed {
        logic [CBCR_POS_W-1:0] cx0;
        logic [CBCR_POS_W-1:0] cy0;
        logic [CBCR_POS_W-1:0] bx;
        logic [CBCR_POS_W-1:0] by;
        logic [CBCR_LEN_W-1:0] rad;
        logic                  cmov;
        logic                  bmov;
        logic                  resolve;
    } t_side;

endpackage

`default_nettype wire

FILE: rtl/cbcr_ifs.sv
// ----------------------------------------------------------------------------
// cbcr request and response channels
// Valid/ready channels carrying one circle/box pair and its result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbcr_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [cbcr_pkg::CBCR_POS_W-1:0]        circle_x;
    logic [cbcr_pkg::CBCR_POS_W-1:0]        circle_y;
    logic [cbcr_pkg::CBCR_LEN_W-1:0]        circle_radius;
    logic [cbcr_pkg::CBCR_POS_W-1:0]        box_x;
    logic [cbcr_pkg::CBCR_POS_W-1:0]        box_y;
    logic [cbcr_pkg::CBCR_LEN_W-1:0]        box_width;
    logic [cbcr_pkg::CBCR_LEN_W-1:0]        box_height;
    logic                                   circle_movable;
    logic                                   box_movable;
    logic                                   resolve_enable;

    modport source (
        output valid, circle_x, circle_y, circle_radius, box_x, box_y,
               box_width, box_height, circle_movable, box_movable, resolve_enable,
        input  ready
    );
    modport sink (
        input  valid, circle_x, circle_y, circle_radius, box_x, box_y,
               box_width, box_height, circle_movable, box_movable, resolve_enable,
        output ready
    );
endinterface

interface cbcr_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [cbcr_pkg::CBCR_POS_W-1:0]    new_circle_x;
    logic [cbcr_pkg::CBCR_POS_W-1:0]    new_circle_y;
    logic [cbcr_pkg::CBCR_POS_W-1:0]    new_box_x;
    logic [cbcr_pkg::CBCR_POS_W-1:0]    new_box_y;

    modport source (
        output valid, hit, new_circle_x, new_circle_y, new_box_x, new_box_y,
        input  ready
    );
    modport sink (
        input  valid, hit, new_circle_x, new_circle_y, new_box_x, new_box_y,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/cbcr_sqrt.sv
// ----------------------------------------------------------------------------
// cbcr_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbcr_sqrt (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire [cbcr_pkg::CBCR_SQ_IN_W-1:0]    i_rad,
    output logic [cbcr_pkg::CBCR_ROOT_W-1:0]    o_root
);

    localparam int IN_W   = cbcr_pkg::CBCR_SQ_IN_W;
    localparam int ROOT_W = cbcr_pkg::CBCR_ROOT_W;
    localparam int REM_W  = cbcr_pkg::CBCR_SQ_REM_W;

    logic [REM_W-1:0]  r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    logic [IN_W-1:0]   r_n    [0:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [IN_W-1:0]   w_n_in;
        logic [REM_W-1:0]  w_rem_sh;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_n_in    = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_n_in    = r_n[s-1];
        end

        // bring down the next two radicand bits, try 4*root + 1
        assign w_rem_sh = {w_rem_in[REM_W-3:0], w_n_in[IN_W-1 -: 2]};
        assign w_trial  = {w_root_in, 2'b01};
        assign w_ge     = (w_rem_sh >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                r_root[s] <= {w_root_in[ROOT_W-2:0], w_ge};
                r_n[s]    <= {w_n_in[IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/cbcr_div.sv
// ----------------------------------------------------------------------------
// cbcr_div
// Pipelined restoring divider, one quotient bit per register stage.
// Dividend upper half must be below the divisor (quotient fits ROOT_W bits).
// ----------------------------------------------------------------------------
`default_nettype none

module cbcr_div (
    input  wire                                 i_clk,
    input  wire                                 i_en,
    input  wire [cbcr_pkg::CBCR_DIV_NUM_W-1:0]  i_num,
    input  wire [cbcr_pkg::CBCR_ROOT_W-1:0]     i_den,
    output logic [cbcr_pkg::CBCR_ROOT_W-1:0]    o_quo
);

    localparam int Q_W = cbcr_pkg::CBCR_ROOT_W;

    logic [Q_W-1:0] r_rem [0:Q_W-1];
    logic [Q_W-1:0] r_low [0:Q_W-1];
    logic [Q_W-1:0] r_den [0:Q_W-1];
    logic [Q_W-1:0] r_quo [0:Q_W-1];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [Q_W-1:0] w_rem_in;
        logic [Q_W-1:0] w_low_in;
        logic [Q_W-1:0] w_den_in;
        logic [Q_W-1:0] w_quo_in;
        logic [Q_W:0]   w_rem_sh;
        logic [Q_W:0]   w_diff;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = i_num[2*Q_W-1:Q_W];
            assign w_low_in = i_num[Q_W-1:0];
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_low_in = r_low[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        assign w_rem_sh = {w_rem_in, w_low_in[Q_W-1]};
        assign w_diff   = w_rem_sh - {1'b0, w_den_in};
        assign w_ge     = (w_rem_sh >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[Q_W-1:0] : w_rem_sh[Q_W-1:0];
                r_low[j] <= {w_low_in[Q_W-2:0], 1'b0};
                r_den[j] <= w_den_in;
                r_quo[j] <= {w_quo_in[Q_W-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/circle_box_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// circle_box_collision_resolve_top
// Circle versus axis-aligned box hit test and push-out correction.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one circle/box request per valid/ready handshake; o_rsp
//   returns one result per request, in request order.
//   From request to result there are four setup stages (centre
//   and box edges, clamp distance, squares, sum and compare), 21 square root
//   stages, two stages for the correction numerator, 21 divider stages and
//   two stages for the signed correction and the saturating update.
//   One request per cycle unless stalled; every stage is one register deep.
//   The whole pipe advances together: i_req.ready is high whenever the
//   output register is empty or is being taken. A stall on o_rsp freezes
//   every stage, so nothing is lost or repeated; bubbles are not squeezed.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits; the data
//   registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_box_collision_resolve_top (
    input  wire             i_clk,
    input  wire             i_rst_n,
    cbcr_req_if.sink        i_req,
    cbcr_rsp_if.source      o_rsp
);

    localparam int POS_W  = cbcr_pkg::CBCR_POS_W;
    localparam int LEN_W  = cbcr_pkg::CBCR_LEN_W;
    localparam int ROOT_W = cbcr_pkg::CBCR_ROOT_W;
    localparam int SQ_W   = 2 * LEN_W;          // one squared term
    localparam int D2_W   = SQ_W + 1;           // sum of two squares

    typedef struct packed {
        logic [LEN_W-1:0] mag;
        logic             big;
        logic             neg;
    } t_axis;

    typedef struct packed {
        cbcr_pkg::t_side  side;
        logic [LEN_W-1:0] adx;
        logic [LEN_W-1:0] ady;
        logic             sx;
        logic             sy;
        logic             hit;
    } t_sq_side;

    typedef struct packed {
        cbcr_pkg::t_side  side;
        logic             hit;
        logic             negx;
        logic             negy;
    } t_dv_side;

    // distance from the centre to the box span on one axis
    function automatic t_axis axis_dist(input logic [POS_W+1:0] c,
                                        input logic [POS_W+1:0] lo,
                                        input logic [POS_W+1:0] hi);
        t_axis            a;
        logic [POS_W+1:0] dhi;
        logic [POS_W+1:0] dlo;
        logic [POS_W:0]   m;
        dhi = c - hi;
        dlo = lo - c;
        if ($signed(c) > $signed(hi)) begin
            m = dhi[POS_W:0];
        end else if ($signed(c) < $signed(lo)) begin
            m = dlo[POS_W:0];
        end else begin
            m = '0;
        end
        a.mag = m[LEN_W-1:0];
        a.big = |m[POS_W:LEN_W];
        a.neg = ($signed(c) < $signed(lo));
        return a;
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W+1:0] v);
        logic [POS_W-1:0] res;
        if ($signed(v) > $signed({3'b000, {(POS_W-1){1'b1}}})) begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end else if ($signed(v) < $signed({3'b111, {(POS_W-1){1'b0}}})) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    logic w_en;

    // ---------------- stage A: centre and far box edges
    logic            r_a_vld;
    cbcr_pkg::t_side r_a_side;
    logic [POS_W:0]  r_a_cx, r_a_cy, r_a_bxh, r_a_byh;

    // ---------------- stage B: per-axis distance
    logic            r_b_vld;
    cbcr_pkg::t_side r_b_side;
    t_axis           r_b_ax, r_b_ay;
    t_axis           w_b_ax, w_b_ay;

    // ---------------- stage C: squares
    logic            r_c_vld;
    cbcr_pkg::t_side r_c_side;
    t_axis           r_c_ax, r_c_ay;
    logic [SQ_W-1:0] r_c_sqx, r_c_sqy, r_c_r2;

    // ---------------- stage D: squared distance and hit
    logic            r_d_vld;
    t_sq_side        r_d_sb;
    logic [D2_W-1:0] r_d_d2;
    logic [D2_W-1:0] w_d_d2;

    // ---------------- square root pipe
    logic [ROOT_W-1:0] r_sq_vld;
    t_sq_side          r_sq_sb [0:ROOT_W-1];
    logic [ROOT_W-1:0] w_root;

    // ---------------- stage E: distance and radius margin
    logic              r_e_vld;
    t_sq_side          r_e_sb;
    logic [ROOT_W-1:0] r_e_dist, r_e_rdmag;
    logic              r_e_rdneg;
    logic [ROOT_W-1:0] w_e_dist;
    logic [ROOT_W:0]   w_e_rd;
    logic [ROOT_W:0]   w_e_rdn;

    // ---------------- stage F: correction numerators
    logic                  r_f_vld;
    t_dv_side              r_f_sb;
    logic [ROOT_W-1:0]     r_f_dist;
    logic [LEN_W+ROOT_W-1:0] r_f_px, r_f_py;

    // ---------------- divider pipe
    logic [ROOT_W-1:0] r_dv_vld;
    t_dv_side          r_dv_sb [0:ROOT_W-1];
    logic [ROOT_W-1:0] w_qx, w_qy;

    // ---------------- stage G: signed, gated corrections
    logic            r_g_vld;
    logic            r_g_hit;
    cbcr_pkg::t_side r_g_side;
    logic [ROOT_W:0] r_g_ccx, r_g_ccy, r_g_bcx, r_g_bcy;
    logic [ROOT_W:0] w_g_cx, w_g_cy;
    logic            w_g_ca, w_g_ba;

    // ---------------- output register
    logic             r_out_vld;
    logic             r_out_hit;
    logic [POS_W-1:0] r_out_ncx, r_out_ncy, r_out_nbx, r_out_nby;

    assign w_en        = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_sq_vld  <= '0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_dv_vld  <= '0;
            r_g_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld   <= i_req.valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_sq_vld  <= {r_sq_vld[ROOT_W-2:0], r_d_vld};
            r_e_vld   <= r_sq_vld[ROOT_W-1];
            r_f_vld   <= r_e_vld;
            r_dv_vld  <= {r_dv_vld[ROOT_W-2:0], r_f_vld};
            r_g_vld   <= r_dv_vld[ROOT_W-1];
            r_out_vld <= r_g_vld;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_side.cx0     <= i_req.circle_x;
            r_a_side.cy0     <= i_req.circle_y;
            r_a_side.bx      <= i_req.box_x;
            r_a_side.by      <= i_req.box_y;
            r_a_side.rad     <= i_req.circle_radius;
            r_a_side.cmov    <= i_req.circle_movable;
            r_a_side.bmov    <= i_req.box_movable;
            r_a_side.resolve <= i_req.resolve_enable;
            r_a_cx  <= {i_req.circle_x[POS_W-1], i_req.circle_x}
                       + {{(POS_W-LEN_W+1){1'b0}}, i_req.circle_radius};
            r_a_cy  <= {i_req.circle_y[POS_W-1], i_req.circle_y}
                       + {{(POS_W-LEN_W+1){1'b0}}, i_req.circle_radius};
            r_a_bxh <= {i_req.box_x[POS_W-1], i_req.box_x}
                       + {{(POS_W-LEN_W+1){1'b0}}, i_req.box_width};
            r_a_byh <= {i_req.box_y[POS_W-1], i_req.box_y}
                       + {{(POS_W-LEN_W+1){1'b0}}, i_req.box_height};
        end
    end

    // stage B
    assign w_b_ax = axis_dist({r_a_cx[POS_W], r_a_cx},
                              {{2{r_a_side.bx[POS_W-1]}}, r_a_side.bx},
                              {r_a_bxh[POS_W], r_a_bxh});
    assign w_b_ay = axis_dist({r_a_cy[POS_W], r_a_cy},
                              {{2{r_a_side.by[POS_W-1]}}, r_a_side.by},
                              {r_a_byh[POS_W], r_a_byh});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_side <= r_a_side;
            r_b_ax   <= w_b_ax;
            r_b_ay   <= w_b_ay;
        end
    end

    // stage C
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_side <= r_b_side;
            r_c_ax   <= r_b_ax;
            r_c_ay   <= r_b_ay;
            r_c_sqx  <= r_b_ax.mag * r_b_ax.mag;
            r_c_sqy  <= r_b_ay.mag * r_b_ay.mag;
            r_c_r2   <= r_b_side.rad * r_b_side.rad;
        end
    end

    // stage D: a distance of 2^LEN_W or more on either axis can never hit
    assign w_d_d2 = {1'b0, r_c_sqx} + {1'b0, r_c_sqy};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_d2      <= w_d_d2;
            r_d_sb.side <= r_c_side;
            r_d_sb.adx  <= r_c_ax.mag;
            r_d_sb.ady  <= r_c_ay.mag;
            r_d_sb.sx   <= r_c_ax.neg;
            r_d_sb.sy   <= r_c_ay.neg;
            r_d_sb.hit  <= !r_c_ax.big && !r_c_ay.big && (w_d_d2 < {1'b0, r_c_r2});
        end
    end

    cbcr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  ({{(cbcr_pkg::CBCR_SQ_IN_W-D2_W){1'b0}}, r_d_d2}),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_sb[0] <= r_d_sb;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sq_sb[k] <= r_sq_sb[k-1];
            end
        end
    end

    // stage E
    assign w_e_dist = (w_root == '0) ? cbcr_pkg::CBCR_DIST_ZERO : w_root;
    assign w_e_rd   = {{(ROOT_W-LEN_W+1){1'b0}}, r_sq_sb[ROOT_W-1].side.rad}
                      - {1'b0, w_e_dist};
    assign w_e_rdn  = '0 - w_e_rd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_sb    <= r_sq_sb[ROOT_W-1];
            r_e_dist  <= w_e_dist;
            r_e_rdneg <= w_e_rd[ROOT_W];
            r_e_rdmag <= w_e_rd[ROOT_W] ? w_e_rdn[ROOT_W-1:0] : w_e_rd[ROOT_W-1:0];
        end
    end

    // stage F
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_sb.side <= r_e_sb.side;
            r_f_sb.hit  <= r_e_sb.hit;
            r_f_sb.negx <= r_e_sb.sx ^ r_e_rdneg;
            r_f_sb.negy <= r_e_sb.sy ^ r_e_rdneg;
            r_f_dist    <= r_e_dist;
            r_f_px      <= r_e_sb.adx * r_e_rdmag;
            r_f_py      <= r_e_sb.ady * r_e_rdmag;
        end
    end

    cbcr_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({{(cbcr_pkg::CBCR_DIV_NUM_W-LEN_W-ROOT_W){1'b0}}, r_f_px}),
        .i_den (r_f_dist),
        .o_quo (w_qx)
    );

    cbcr_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({{(cbcr_pkg::CBCR_DIV_NUM_W-LEN_W-ROOT_W){1'b0}}, r_f_py}),
        .i_den (r_f_dist),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_sb[0] <= r_f_sb;
            for (int k = 1; k < ROOT_W; k++) begin
                r_dv_sb[k] <= r_dv_sb[k-1];
            end
        end
    end

    // stage G: quotient of magnitudes, sign restored (truncates toward zero)
    assign w_g_cx = r_dv_sb[ROOT_W-1].negx ? ('0 - {1'b0, w_qx}) : {1'b0, w_qx};
    assign w_g_cy = r_dv_sb[ROOT_W-1].negy ? ('0 - {1'b0, w_qy}) : {1'b0, w_qy};
    assign w_g_ca = r_dv_sb[ROOT_W-1].hit && r_dv_sb[ROOT_W-1].side.resolve
                    && r_dv_sb[ROOT_W-1].side.cmov;
    assign w_g_ba = r_dv_sb[ROOT_W-1].hit && r_dv_sb[ROOT_W-1].side.resolve
                    && r_dv_sb[ROOT_W-1].side.bmov;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_side <= r_dv_sb[ROOT_W-1].side;
            r_g_hit  <= r_dv_sb[ROOT_W-1].hit;
            r_g_ccx  <= w_g_ca ? w_g_cx : '0;
            r_g_ccy  <= w_g_ca ? w_g_cy : '0;
            r_g_bcx  <= w_g_ba ? w_g_cx : '0;
            r_g_bcy  <= w_g_ba ? w_g_cy : '0;
        end
    end

    // output register: apply and saturate
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= r_g_hit;
            r_out_ncx <= sat_pos({{2{r_g_side.cx0[POS_W-1]}}, r_g_side.cx0}
                                 + {{(POS_W-ROOT_W+1){r_g_ccx[ROOT_W]}}, r_g_ccx});
            r_out_ncy <= sat_pos({{2{r_g_side.cy0[POS_W-1]}}, r_g_side.cy0}
                                 + {{(POS_W-ROOT_W+1){r_g_ccy[ROOT_W]}}, r_g_ccy});
            r_out_nbx <= sat_pos({{2{r_g_side.bx[POS_W-1]}}, r_g_side.bx}
                                 - {{(POS_W-ROOT_W+1){r_g_bcx[ROOT_W]}}, r_g_bcx});
            r_out_nby <= sat_pos({{2{r_g_side.by[POS_W-1]}}, r_g_side.by}
                                 - {{(POS_W-ROOT_W+1){r_g_bcy[ROOT_W]}}, r_g_bcy});
        end
    end

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out_hit;
    assign o_rsp.new_circle_x = r_out_ncx;
    assign o_rsp.new_circle_y = r_out_ncy;
    assign o_rsp.new_box_x    = r_out_nbx;
    assign o_rsp.new_box_y    = r_out_nby;

    // ---------------- checks
    logic [3:0] w_vld_vec;
    logic       w_sq_hit;
    logic       w_g_nocor;

    assign w_vld_vec = {r_a_vld, r_e_vld, r_g_vld, r_out_vld};
    assign w_sq_hit  = r_sq_vld[ROOT_W-1] && r_sq_sb[ROOT_W-1].hit && (w_root != '0);
    assign w_g_nocor = (r_g_ccx == '0) && (r_g_ccy == '0)
                       && (r_g_bcx == '0) && (r_g_bcy == '0);

`include "circle_box_collision_resolve_top_assert.svh"

    `CBCR_ASSERT_SAME(a_root_below_radius, i_clk, i_rst_n, w_sq_hit, w_root < {1'b0, r_sq_sb[ROOT_W-1].side.rad}, "root not below radius on a hit")
    `CBCR_ASSERT_SAME(a_no_hit_no_move, i_clk, i_rst_n, r_g_vld && !r_g_hit, w_g_nocor, "correction without a hit")
    `CBCR_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, !w_en, $stable(w_vld_vec), "pipe moved during stall")

endmodule

`default_nettype wire

FILE: dv/tb_circle_box_collision_resolve_top.sv
// ----------------------------------------------------------------------------
// tb_circle_box_collision_resolve_top
// Streams circle/box pairs through the collision block and checks every
// result against a cycle-free predictor of the hit test and push-out math.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circle_box_collision_resolve_top;

    localparam int  POS_W       = cbcr_pkg::CBCR_POS_W;
    localparam int  LEN_W       = cbcr_pkg::CBCR_LEN_W;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1530;
    localparam int  LATENCY     = 50;
    localparam longint POS_HI   = 8388607;
    localparam longint POS_LO   = -8388608;

    typedef struct {
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [LEN_W-1:0] rad;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic [LEN_W-1:0] bw;
        logic [LEN_W-1:0] bh;
        logic             cmov;
        logic             bmov;
        logic             resolve;
    } t_pair;

    typedef struct {
        logic             hit;
        logic [POS_W-1:0] ncx;
        logic [POS_W-1:0] ncy;
        logic [POS_W-1:0] nbx;
        logic [POS_W-1:0] nby;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    cbcr_req_if req_ch ();
    cbcr_rsp_if rsp_ch ();

    circle_box_collision_resolve_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_pair    pending_pairs[$];
    t_outcome expected_outcomes[$];
    int       cycle_cnt;
    int       n_sent;
    int       n_checked;
    int       n_hits;
    int       n_errors;
    int       hold_left;
    bit       hold_done;
    bit       req_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic longint floor_sqrt(input longint n);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) << 60;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [POS_W-1:0] saturate_pos(input longint v);
        if (v > POS_HI) v = POS_HI;
        if (v < POS_LO) v = POS_LO;
        return v[POS_W-1:0];
    endfunction

    function automatic t_outcome resolve_pair(input t_pair p);
        t_outcome o;
        longint cx0, cy0, bx, by, r, cx, cy, kx, ky, dx, dy, d2, dlen, corx, cory;
        longint ncx, ncy, nbx, nby;
        cx0 = longint'($signed(p.cx));
        cy0 = longint'($signed(p.cy));
        bx  = longint'($signed(p.bx));
        by  = longint'($signed(p.by));
        r   = longint'(p.rad);
        cx  = cx0 + r;
        cy  = cy0 + r;
        kx  = cx;
        if (kx > bx + longint'(p.bw)) kx = bx + longint'(p.bw);
        if (kx < bx) kx = bx;
        ky  = cy;
        if (ky > by + longint'(p.bh)) ky = by + longint'(p.bh);
        if (ky < by) ky = by;
        dx  = cx - kx;
        dy  = cy - ky;
        d2  = dx * dx + dy * dy;
        o.hit = (d2 < r * r);
        ncx = cx0; ncy = cy0; nbx = bx; nby = by;
        if (o.hit && p.resolve) begin
            dlen = floor_sqrt(d2);
            // centre on the box: substitute the small fixed-point distance
            if (dlen == 0) dlen = longint'(cbcr_pkg::CBCR_DIST_INT);
            corx = (dx * (r - dlen)) / dlen;
            cory = (dy * (r - dlen)) / dlen;
            if (p.cmov) begin
                ncx += corx;
                ncy += cory;
            end
            if (p.bmov) begin
                nbx -= corx;
                nby -= cory;
            end
        end
        o.ncx = saturate_pos(ncx);
        o.ncy = saturate_pos(ncy);
        o.nbx = saturate_pos(nbx);
        o.nby = saturate_pos(nby);
        return o;
    endfunction

    function automatic t_pair make_pair(input longint cx, cy, r, bx, by, bw, bh,
                                        input bit cm, bm, re);
        t_pair p;
        p.cx = cx[POS_W-1:0];
        p.cy = cy[POS_W-1:0];
        p.rad = r[LEN_W-1:0];
        p.bx = bx[POS_W-1:0];
        p.by = by[POS_W-1:0];
        p.bw = bw[LEN_W-1:0];
        p.bh = bh[LEN_W-1:0];
        p.cmov = cm;
        p.bmov = bm;
        p.resolve = re;
        return p;
    endfunction

    // mostly near-contact pairs with small sizes; some raw noise and huge ones
    function automatic t_pair random_pair();
        t_pair  p;
        longint r, bw, bh, bx, by, cx, cy;
        int     sel;
        sel = int'($urandom_range(0, 99));
        if (sel < 12) begin
            p.cx = POS_W'($urandom); p.cy = POS_W'($urandom); p.rad = LEN_W'($urandom);
            p.bx = POS_W'($urandom); p.by = POS_W'($urandom);
            p.bw = LEN_W'($urandom); p.bh = LEN_W'($urandom);
            p.cmov = 1'($urandom); p.bmov = 1'($urandom); p.resolve = 1'($urandom);
            return p;
        end
        if (sel < 20) begin
            r  = longint'($urandom_range(0, 1048575));
            bw = longint'($urandom_range(0, 1048575));
            bh = longint'($urandom_range(0, 1048575));
            bx = (sel < 16) ? POS_HI - longint'($urandom_range(0, 1048575))
                            : POS_LO + longint'($urandom_range(0, 1048575));
        end else begin
            r  = longint'($urandom_range(0, 4096));
            bw = longint'($urandom_range(0, 6000));
            bh = longint'($urandom_range(0, 6000));
            bx = longint'($signed(24'($urandom))) / 4;
        end
        by = (sel < 20) ? bx + longint'($urandom_range(0, 2048)) - 1024
                        : longint'($signed(24'($urandom))) / 4;
        cx = bx - 2 * r - 8 + longint'($urandom_range(0, 32'(bw + 2 * r + 16)));
        cy = by - 2 * r - 8 + longint'($urandom_range(0, 32'(bh + 2 * r + 16)));
        if (cx > POS_HI) cx = POS_HI;
        if (cx < POS_LO) cx = POS_LO;
        if (cy > POS_HI) cy = POS_HI;
        if (cy < POS_LO) cy = POS_LO;
        if (bx + bw > POS_HI + 1048575) bx = POS_HI;
        return make_pair(cx, cy, r, bx, by, bw, bh,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) != 0);
    endfunction

    // ------------------------------------------------------------------
    // request driver: changes at the falling edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        req_taken = req_ch.valid && req_ch.ready && i_rst_n;
        if (req_taken) begin
            expected_outcomes.push_back(resolve_pair(t_pair'{
                req_ch.circle_x, req_ch.circle_y, req_ch.circle_radius,
                req_ch.box_x, req_ch.box_y, req_ch.box_width, req_ch.box_height,
                req_ch.circle_movable, req_ch.box_movable, req_ch.resolve_enable}));
            n_sent++;
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout at %0t after %0d cycles", $time, cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        t_pair p;
        bit    no_idle;
        no_idle = (cycle_cnt > 2500 && cycle_cnt < 4000);
        if (i_rst_n && (!req_ch.valid || req_taken)) begin
            if (pending_pairs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 30)) begin
                p = pending_pairs.pop_front();
                req_ch.valid          = 1'b1;
                req_ch.circle_x       = p.cx;
                req_ch.circle_y       = p.cy;
                req_ch.circle_radius  = p.rad;
                req_ch.box_x          = p.bx;
                req_ch.box_y          = p.by;
                req_ch.box_width      = p.bw;
                req_ch.box_height     = p.bh;
                req_ch.circle_movable = p.cmov;
                req_ch.box_movable    = p.bmov;
                req_ch.resolve_enable = p.resolve;
            end else begin
                req_ch.valid = 1'b0;
            end
            req_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // response side: ready at the falling edge, check at the rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!hold_done && n_sent >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;    // long back-pressure so the pipe stalls
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
        end else if (cycle_cnt > 2500 && cycle_cnt < 4000) begin
            rsp_ch.ready = 1'b1;
        end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result hit=%0b cx=%h cy=%h bx=%h by=%h", $time,
                         rsp_ch.hit, rsp_ch.new_circle_x, rsp_ch.new_circle_y,
                         rsp_ch.new_box_x, rsp_ch.new_box_y);
                n_errors++;
            end else begin
                e = expected_outcomes.pop_front();
                n_checked++;
                if (e.hit) n_hits++;
                if (rsp_ch.hit !== e.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, e.hit, rsp_ch.hit);
                    n_errors++;
                end
                if (rsp_ch.new_circle_x !== e.ncx) begin
                    $display("%0t: new_circle_x expected %h actual %h", $time, e.ncx,
                             rsp_ch.new_circle_x);
                    n_errors++;
                end
                if (rsp_ch.new_circle_y !== e.ncy) begin
                    $display("%0t: new_circle_y expected %h actual %h", $time, e.ncy,
                             rsp_ch.new_circle_y);
                    n_errors++;
                end
                if (rsp_ch.new_box_x !== e.nbx) begin
                    $display("%0t: new_box_x expected %h actual %h", $time, e.nbx,
                             rsp_ch.new_box_x);
                    n_errors++;
                end
                if (rsp_ch.new_box_y !== e.nby) begin
                    $display("%0t: new_box_y expected %h actual %h", $time, e.nby,
                             rsp_ch.new_box_y);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        cycle_cnt = 0; n_sent = 0; n_checked = 0; n_hits = 0; n_errors = 0;
        hold_left = 0; hold_done = 1'b0; req_taken = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.circle_x = '0; req_ch.circle_y = '0; req_ch.circle_radius = '0;
        req_ch.box_x = '0; req_ch.box_y = '0; req_ch.box_width = '0;
        req_ch.box_height = '0; req_ch.circle_movable = 1'b0;
        req_ch.box_movable = 1'b0; req_ch.resolve_enable = 1'b0;
        rsp_ch.ready = 1'b0;

        // zero radius, centre on the box, touching exactly, several flag mixes
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 256, 256, 1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 1024, 1024, 1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 1024, 1024, 0, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 1024, 1024, 1, 0, 1));
        pending_pairs.push_back(make_pair(0, 0, 256, 0, 0, 1024, 1024, 1, 1, 0));
        pending_pairs.push_back(make_pair(-512, 0, 256, 0, 0, 1024, 1024, 1, 1, 1));
        pending_pairs.push_back(make_pair(-500, 0, 256, 0, 0, 1024, 1024, 1, 1, 1));
        pending_pairs.push_back(make_pair(-400, -400, 256, 0, 0, 1024, 1024, 1, 0, 1));
        pending_pairs.push_back(make_pair(1000, 1000, 300, 0, 0, 1024, 1024, 0, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 1048575, 0, 0, 0, 0, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_HI, POS_HI, 1048575, POS_LO, POS_LO,
                                          1048575, 1048575, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_LO, POS_LO, 1048575, POS_HI, POS_HI,
                                          1048575, 1048575, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_HI - 1048575, POS_HI - 1048575, 1048575,
                                          POS_HI - 1500000, POS_HI - 1500000,
                                          1000, 1000, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_LO, POS_LO, 1048575, POS_LO + 1100000,
                                          POS_LO + 1100000, 1048575, 1048575, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_LO, POS_HI, 1048575, POS_HI, POS_LO,
                                          1048575, 1048575, 1, 1, 1));
        pending_pairs.push_back(make_pair(-1, -1, 1, -1, -1, 1, 1, 1, 1, 1));
        pending_pairs.push_back(make_pair(100, 0, 50, 0, 0, 0, 1048575, 1, 1, 1));
        pending_pairs.push_back(make_pair(POS_HI, POS_LO, 1048575, POS_HI, POS_LO,
                                          1048575, 1048575, 0, 0, 1));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender pauses until the directed results are all back
        wait (pending_pairs.size() == 0 && !req_ch.valid && expected_outcomes.size() == 0);
        for (int k = 0; k < N_RANDOM; k++) pending_pairs.push_back(random_pair());

        wait (pending_pairs.size() == 0 && !req_ch.valid && expected_outcomes.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d hits, incl. saturation and",
                 n_sent, n_checked, n_hits);
        $display("zero-distance cases, long output stall and idle-free stretch");
        if (n_errors == 0 && expected_outcomes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
